// File: sv/bsp_pkg.sv
package bsp_pkg;

  localparam int ROW_W = 16;
  localparam int PAL_W = 16;
  localparam int GEN_W = 32;
  localparam int VER_W = 32;
  localparam int OP_W = 2;
  localparam int SLOT_W = 2;
  localparam int OUTCOME_W = 3;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUT_HIT_ACTIVE = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_HIT_SWITCH = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_STALE = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_FREE_SLOT = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_CLEARED = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ROW_W-1:0] palette_row;
    logic [PAL_W-1:0] palette_id;
    logic [GEN_W-1:0] palette_generation;
    logic [VER_W-1:0] content_version;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [OUTCOME_W-1:0] outcome;
    logic needs_rebuild;
  } rsp_t;

  // match flags rippled along the row of cells
  typedef struct packed {
    logic hit;
    logic stale;
    logic empty;
  } chain_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } cell_ctl_t;

endpackage

// File: sv/bsp_cell.sv
module bsp_cell
  import bsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  cell_ctl_t ctl,
  input  chain_t    prev,
  output chain_t    next,
  output chain_t    first
);

  logic             valid;
  logic [ROW_W-1:0] row;
  logic [PAL_W-1:0] pal;
  logic [GEN_W-1:0] gen;
  logic [VER_W-1:0] ver;
  logic             rp_match;
  chain_t           here;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      row <= req.palette_row;
      pal <= req.palette_id;
      gen <= req.palette_generation;
      ver <= req.content_version;
    end
  end

  assign rp_match = valid && (row == req.palette_row) && (pal == req.palette_id);

  always_comb begin
    here.hit   = rp_match && (gen == req.palette_generation) &&
                 (ver == req.content_version);
    here.stale = rp_match;
    here.empty = !valid;
    first      = here & ~prev;
    next       = here | prev;
  end

endmodule

// File: sv/baked_store_slot_policy.sv
// Flow: an accepted request is held in the cur register; its result is written to the response
// register when the request fires, which waits while the response register stays stalled.
// Throughput: one request per cycle while the response register is not stalled; all slot
// cells compare in the same cycle and the first-match flags ripple along the cell row.
// Reset: synchronous, active high; clears all slot valid bits, the active mark,
// the round-robin pointer and the handshake state. Tags are not reset.
module baked_store_slot_policy
  import bsp_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic            pending;
  req_t            cur;
  logic            fire;
  logic            active_present;
  logic [IDXW-1:0] active_index;
  logic [IDXW-1:0] victim;

  chain_t          chain [SLOTS+1];
  chain_t          first [SLOTS];
  cell_ctl_t       ctl   [SLOTS];

  logic [IDXW-1:0] hit_idx;
  logic [IDXW-1:0] stale_idx;
  logic [IDXW-1:0] empty_idx;
  logic [IDXW-1:0] chosen;
  logic [OUTCOME_W-1:0] outcome;
  logic            is_lookup;
  logic            is_clear;
  logic            miss;

  assign fire      = pending && (!rsp_valid || !rsp_stall);
  assign req_stall = pending && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (req_valid && !req_stall) begin
      pending <= 1'b1;
    end else if (fire) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cur <= req;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bsp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .req   (cur),
      .ctl   (ctl[i]),
      .prev  (chain[i]),
      .next  (chain[i+1]),
      .first (first[i])
    );
  end

  always_comb begin
    hit_idx   = '0;
    stale_idx = '0;
    empty_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i].hit) hit_idx = hit_idx | IDXW'(i);
      if (first[i].stale) stale_idx = stale_idx | IDXW'(i);
      if (first[i].empty) empty_idx = empty_idx | IDXW'(i);
    end
  end

  assign is_lookup = (cur.operation == OP_LOOKUP);
  assign is_clear  = (cur.operation == OP_INVALIDATE) || (cur.operation == OP_FREE);

  always_comb begin
    chosen  = '0;
    outcome = OUT_CLEARED;
    miss    = 1'b0;
    if (is_lookup) begin
      if (chain[SLOTS].hit) begin
        chosen  = hit_idx;
        outcome = (active_present && active_index == hit_idx) ? OUT_HIT_ACTIVE
                                                              : OUT_HIT_SWITCH;
      end else if (chain[SLOTS].stale) begin
        chosen  = stale_idx;
        outcome = OUT_STALE;
        miss    = 1'b1;
      end else if (chain[SLOTS].empty) begin
        chosen  = empty_idx;
        outcome = OUT_FREE_SLOT;
        miss    = 1'b1;
      end else begin
        chosen  = victim;
        outcome = OUT_EVICT;
        miss    = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i].wr  = fire && miss && (chosen == IDXW'(i));
      ctl[i].clr = fire && is_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_present <= 1'b0;
      active_index   <= '0;
      victim         <= '0;
    end else if (fire) begin
      if (is_clear) begin
        active_present <= 1'b0;
      end else if (is_lookup) begin
        active_present <= 1'b1;
        active_index   <= chosen;
      end
      if (cur.operation == OP_FREE) begin
        victim <= '0;
      end else if (is_lookup && outcome == OUT_EVICT) begin
        victim <= (victim == IDXW'(SLOTS - 1)) ? '0 : victim + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.slot          <= SLOT_W'(chosen);
      rsp.outcome       <= outcome;
      rsp.needs_rebuild <= miss;
    end
  end

endmodule
